// File: rtl/fvp_pkg.sv
`timescale 1ns / 1ps
package fvp_pkg;

  localparam int INTEGRAL_BOUND_DEF = 10000;
  localparam int FRAC_BITS_DEF      = 8;

  localparam int FILT_W     = 32;
  localparam int ERR_W      = 18;
  localparam int GAIN_W     = 16;
  localparam int TILT_W     = 16;
  localparam int LIMIT_W    = 15;
  localparam int BATT_W     = 12;
  localparam int TARGET_W   = 8;
  localparam int DRIVE_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int COEF_NEW   = 41;
  localparam int COEF_OLD   = 215;
  localparam int FILT_SHIFT = 8;

  localparam int DRIVE_DIVISOR = 100;
  localparam int Q_BITS        = 16;
  localparam int DRIVE_MAX     = 32767;

  localparam logic [LIMIT_W-1:0] TILT_LIMIT_RST  = LIMIT_W'(4000);
  localparam logic [BATT_W-1:0]  LOW_BATTERY_RST = BATT_W'(1170);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 2'd0,
    REG_INTEG_GAIN  = 2'd1,
    REG_TILT_LIMIT  = 2'd2,
    REG_LOW_BATTERY = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILT_ERR,
    S_FILT_OLD,
    S_INTEG,
    S_MUL_P,
    S_MUL_I,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
  } mac_ctrl_t;

endpackage

// File: rtl/filtered_velocity_pi.sv
`timescale 1ns / 1ps
// Sequence per request: filter update on the bit-serial shift-add unit, integral update,
// proportional and integral products, then the 16-step restoring divider, then out_valid.
// A new request is accepted only in the idle state, after the previous result has been
// loaded into the output register.
// Reset (rst, synchronous): filter and integral cleared, gains 0, tilt limit 4000,
// battery threshold 1170, no result pending.
module filtered_velocity_pi #(
  parameter int INTEGRAL_BOUND = fvp_pkg::INTEGRAL_BOUND_DEF,
  parameter int FRAC_BITS      = fvp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fvp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fvp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [15:0]                  left_count,
  input  logic signed [15:0]                  right_count,
  input  logic signed [fvp_pkg::TARGET_W-1:0] target_speed,
  input  logic signed [fvp_pkg::TILT_W-1:0]   tilt_angle,
  input  logic [fvp_pkg::BATT_W-1:0]          battery_level,
  input  logic                                stop_request,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fvp_pkg::DRIVE_W-1:0]  drive_value,
  output logic                                motors_off
);

  localparam longint IBND_L = longint'(INTEGRAL_BOUND) << FRAC_BITS;
  localparam int I_W   = $clog2(IBND_L + 1) + 1;
  localparam int WIDE  = (I_W > fvp_pkg::FILT_W) ? I_W : fvp_pkg::FILT_W;
  localparam int SUM_W = WIDE + 1;
  localparam int ACC_W = WIDE + fvp_pkg::GAIN_W + 2;
  localparam logic signed [SUM_W-1:0] IBND_POS = SUM_W'(IBND_L);
  localparam logic signed [SUM_W-1:0] IBND_NEG = -IBND_POS;
  localparam int FW = fvp_pkg::FILT_W;

  logic [fvp_pkg::GAIN_W-1:0]  prop_gain;
  logic [fvp_pkg::GAIN_W-1:0]  integ_gain;
  logic [fvp_pkg::LIMIT_W-1:0] tilt_limit;
  logic [fvp_pkg::BATT_W-1:0]  low_battery;

  fvp_pkg::state_t state, state_next;

  logic signed [FW-1:0]  filt;
  logic signed [I_W-1:0] integ;
  logic                  off_flag;
  logic                  acc_neg;

  fvp_pkg::mac_ctrl_t          mac_ctrl;
  logic signed [ACC_W-1:0]     mac_mcand;
  logic [fvp_pkg::GAIN_W-1:0]  mac_mplier;
  logic signed [ACC_W-1:0]     acc;
  logic                        mac_idle;

  logic                        div_start;
  logic                        div_done;
  logic [ACC_W-1:0]            div_dividend;
  logic [fvp_pkg::Q_BITS-1:0]  div_q;

  logic signed [fvp_pkg::ERR_W-1:0] err;
  logic signed [fvp_pkg::TILT_W:0]  tilt_ext;
  logic signed [fvp_pkg::TILT_W:0]  lim_ext;
  logic                             off_now;
  logic signed [ACC_W-1:0]          filt_wide;
  logic                             filt_hi;
  logic                             filt_lo;
  logic signed [FW-1:0]             filt_sat;
  logic signed [SUM_W-1:0]          integ_sum;
  logic signed [I_W-1:0]            integ_sat;
  logic [fvp_pkg::DRIVE_W-1:0]      drive_mag;
  logic                             in_fire;
  logic                             out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      tilt_limit  <= fvp_pkg::TILT_LIMIT_RST;
      low_battery <= fvp_pkg::LOW_BATTERY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        fvp_pkg::REG_PROP_GAIN:   prop_gain   <= cfg_data;
        fvp_pkg::REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        fvp_pkg::REG_TILT_LIMIT:  tilt_limit  <= cfg_data[fvp_pkg::LIMIT_W-1:0];
        fvp_pkg::REG_LOW_BATTERY: low_battery <= cfg_data[fvp_pkg::BATT_W-1:0];
        default: ;
      endcase
    end
  end

  assign err = fvp_pkg::ERR_W'(target_speed)
             - (fvp_pkg::ERR_W'(left_count) + fvp_pkg::ERR_W'(right_count));

  assign tilt_ext = (fvp_pkg::TILT_W + 1)'(tilt_angle);
  assign lim_ext  = $signed({2'b00, tilt_limit});
  assign off_now  = (tilt_ext > lim_ext) || (tilt_ext < -lim_ext) || stop_request
                 || (battery_level < low_battery);

  // floor(acc / 256), saturated to 32 bits
  assign filt_wide = acc >>> fvp_pkg::FILT_SHIFT;
  assign filt_hi   = !filt_wide[ACC_W-1] && (|filt_wide[ACC_W-2:FW-1]);
  assign filt_lo   = filt_wide[ACC_W-1] && !(&filt_wide[ACC_W-2:FW-1]);
  always_comb begin
    if (filt_hi) begin
      filt_sat = {1'b0, {(FW-1){1'b1}}};
    end else if (filt_lo) begin
      filt_sat = {1'b1, {(FW-1){1'b0}}};
    end else begin
      filt_sat = filt_wide[FW-1:0];
    end
  end

  assign integ_sum = SUM_W'(integ) + SUM_W'(filt);
  always_comb begin
    if (integ_sum > IBND_POS) begin
      integ_sat = IBND_POS[I_W-1:0];
    end else if (integ_sum < IBND_NEG) begin
      integ_sat = IBND_NEG[I_W-1:0];
    end else begin
      integ_sat = integ_sum[I_W-1:0];
    end
  end

  assign div_dividend = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign drive_mag = div_q[fvp_pkg::Q_BITS-1] ? fvp_pkg::DRIVE_W'(fvp_pkg::DRIVE_MAX)
                                              : {1'b0, div_q[fvp_pkg::Q_BITS-2:0]};

  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == fvp_pkg::S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fvp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mac_ctrl   = '0;
    mac_mcand  = '0;
    mac_mplier = '0;
    div_start  = 1'b0;
    case (state)
      fvp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mac_ctrl.load  = 1'b1;
          mac_ctrl.clear = 1'b1;
          mac_mcand      = ACC_W'(err) <<< FRAC_BITS;
          mac_mplier     = fvp_pkg::GAIN_W'(fvp_pkg::COEF_NEW);
          state_next     = fvp_pkg::S_FILT_ERR;
        end
      end
      fvp_pkg::S_FILT_ERR: begin
        if (mac_idle) begin
          mac_ctrl.load = 1'b1;
          mac_mcand     = ACC_W'(filt);
          mac_mplier    = fvp_pkg::GAIN_W'(fvp_pkg::COEF_OLD);
          state_next    = fvp_pkg::S_FILT_OLD;
        end
      end
      fvp_pkg::S_FILT_OLD: begin
        if (mac_idle) begin
          state_next = fvp_pkg::S_INTEG;
        end
      end
      fvp_pkg::S_INTEG: begin
        mac_ctrl.load  = 1'b1;
        mac_ctrl.clear = 1'b1;
        mac_mcand      = ACC_W'(filt);
        mac_mplier     = prop_gain;
        state_next     = fvp_pkg::S_MUL_P;
      end
      fvp_pkg::S_MUL_P: begin
        if (mac_idle) begin
          mac_ctrl.load = 1'b1;
          mac_mcand     = {{(ACC_W-I_W){integ[I_W-1]}}, integ};
          mac_mplier    = integ_gain;
          state_next    = fvp_pkg::S_MUL_I;
        end
      end
      fvp_pkg::S_MUL_I: begin
        if (mac_idle) begin
          div_start  = 1'b1;
          state_next = fvp_pkg::S_DIV;
        end
      end
      fvp_pkg::S_DIV: begin
        if (div_done) begin
          state_next = fvp_pkg::S_DONE;
        end
      end
      fvp_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = fvp_pkg::S_IDLE;
        end
      end
      default: state_next = fvp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt  <= '0;
      integ <= '0;
    end else begin
      if (state == fvp_pkg::S_FILT_OLD && mac_idle) begin
        filt <= filt_sat;
      end
      if (state == fvp_pkg::S_INTEG) begin
        integ <= integ_sat;
      end else if (state == fvp_pkg::S_MUL_I && mac_idle && off_flag) begin
        integ <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      off_flag <= off_now;
    end
    if (div_start) begin
      acc_neg <= acc[ACC_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // drive = trunc(-acc / (divisor << FRAC_BITS)), magnitude saturated to 32767: sign flips relative to acc
  always_ff @(posedge clk) begin
    if (out_load) begin
      drive_value <= acc_neg ? $signed(drive_mag) : -$signed(drive_mag);
      motors_off  <= off_flag;
    end
  end

  fvp_mac #(
    .ACC_W(ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (mac_ctrl),
    .mcand_in (mac_mcand),
    .mplier_in(mac_mplier),
    .acc      (acc),
    .idle     (mac_idle)
  );

  fvp_div #(
    .ACC_W    (ACC_W),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .done    (div_done),
    .quotient(div_q)
  );

`ifndef SYNTH
  a_integ_bound: assert property (@(posedge clk) disable iff (rst)
    (SUM_W'(integ) <= IBND_POS) && (SUM_W'(integ) >= IBND_NEG))
    else $error("integral outside bound");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == fvp_pkg::S_DIV))
    else $error("divider finished outside divide phase");

  a_mac_idle_integ: assert property (@(posedge clk) disable iff (rst)
    (state == fvp_pkg::S_INTEG) |-> mac_idle)
    else $error("shift-add unit busy at integral update");

  a_off_clears: assert property (@(posedge clk) disable iff (rst)
    ((state == fvp_pkg::S_DONE) && off_flag) |-> (integ == '0))
    else $error("integral not cleared on shutdown");
`endif

endmodule

// File: rtl/fvp_mac.sv
`timescale 1ns / 1ps
module fvp_mac #(
  parameter int ACC_W = 50
) (
  input  logic                     clk,
  input  logic                     rst,
  input  fvp_pkg::mac_ctrl_t       ctrl,
  input  logic signed [ACC_W-1:0]  mcand_in,
  input  logic [fvp_pkg::GAIN_W-1:0] mplier_in,
  output logic signed [ACC_W-1:0]  acc,
  output logic                     idle
);

  logic signed [ACC_W-1:0]        mcand;
  logic [fvp_pkg::GAIN_W-1:0]     mplier;

  always_ff @(posedge clk) begin
    if (rst) begin
      mplier <= '0;
    end else if (ctrl.load) begin
      mplier <= mplier_in;
    end else begin
      mplier <= mplier >> 1;
    end
  end

  // one multiplier bit per cycle, LSB first
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mcand <= mcand_in;
      if (ctrl.clear) begin
        acc <= '0;
      end
    end else if (mplier != '0) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= mcand <<< 1;
    end
  end

  assign idle = (mplier == '0);

endmodule

// File: rtl/fvp_div.sv
`timescale 1ns / 1ps
module fvp_div #(
  parameter int ACC_W     = 50,
  parameter int FRAC_BITS = fvp_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [ACC_W-1:0]           dividend,
  output logic                       done,
  output logic [fvp_pkg::Q_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(fvp_pkg::Q_BITS + 1);
  localparam logic [ACC_W-1:0] DSR_INIT =
    ACC_W'(fvp_pkg::DRIVE_DIVISOR) << (FRAC_BITS + fvp_pkg::Q_BITS - 1);

  logic [ACC_W-1:0] rem;
  logic [ACC_W-1:0] dsr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= CNT_W'(fvp_pkg::Q_BITS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - CNT_W'(1);
      done  <= (count == CNT_W'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle; top bit flags overflow
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= DSR_INIT;
      quotient <= '0;
    end else if (count != '0) begin
      if (rem >= dsr) begin
        rem      <= rem - dsr;
        quotient <= {quotient[fvp_pkg::Q_BITS-2:0], 1'b1};
      end else begin
        quotient <= {quotient[fvp_pkg::Q_BITS-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end
  end

endmodule
